// File: rtl/lrf_pkg.sv
// lrf_pkg: shared types and constants for the lcd rectangle fill byte sequencer
// no dependencies; imported by every other file of the block except lrf_res_if
`timescale 1ns / 1ps

package lrf_pkg;

  localparam int DIM_BITS      = 10;
  localparam int OFF_BITS      = 10;
  localparam int ADDR_BITS     = 16;
  localparam int FIELD_BITS    = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (DIM_BITS > OFF_BITS) ? DIM_BITS : OFF_BITS;
  localparam int PHASE_BITS    = 4;

  localparam logic KIND_FILL    = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLUMN_OFF   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_OFF      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROTATION     = 3'd4;

  localparam logic [DIM_BITS-1:0] PANEL_DIM_RESET = DIM_BITS'(240);

  localparam logic [7:0] CMD_COLSET = 8'h2A;
  localparam logic [7:0] CMD_ROWSET = 8'h2B;
  localparam logic [7:0] CMD_MEMWR  = 8'h2C;

  localparam logic [PHASE_BITS-1:0] PH_COLSET    = 4'd0;
  localparam logic [PHASE_BITS-1:0] PH_COL_S_HI  = 4'd1;
  localparam logic [PHASE_BITS-1:0] PH_COL_S_LO  = 4'd2;
  localparam logic [PHASE_BITS-1:0] PH_COL_E_HI  = 4'd3;
  localparam logic [PHASE_BITS-1:0] PH_COL_E_LO  = 4'd4;
  localparam logic [PHASE_BITS-1:0] PH_ROWSET    = 4'd5;
  localparam logic [PHASE_BITS-1:0] PH_ROW_S_HI  = 4'd6;
  localparam logic [PHASE_BITS-1:0] PH_ROW_S_LO  = 4'd7;
  localparam logic [PHASE_BITS-1:0] PH_ROW_E_HI  = 4'd8;
  localparam logic [PHASE_BITS-1:0] PH_ROW_E_LO  = 4'd9;
  localparam logic [PHASE_BITS-1:0] PH_MEMWR     = 4'd10;
  localparam logic [PHASE_BITS-1:0] PH_PIXELS    = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_BYTE     = 3'd1,
    ST_ACCEPTED = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_REFUSED  = 3'd4
  } status_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] panel_width;
    logic [DIM_BITS-1:0] panel_height;
    logic [OFF_BITS-1:0] column_offset;
    logic [OFF_BITS-1:0] row_offset;
    logic [1:0]          rotation;
  } cfg_t;

  typedef struct packed {
    logic                  kind;
    logic [FIELD_BITS-1:0] rect_x;
    logic [FIELD_BITS-1:0] rect_y;
    logic [FIELD_BITS-1:0] rect_w;
    logic [FIELD_BITS-1:0] rect_h;
    logic [FIELD_BITS-1:0] fill_color;
  } req_t;

  typedef struct packed {
    logic                 ok;
    logic [ADDR_BITS-1:0] col_start;
    logic [ADDR_BITS-1:0] col_end;
    logic [ADDR_BITS-1:0] row_start;
    logic [ADDR_BITS-1:0] row_end;
    logic [DIM_BITS-1:0]  cols;
    logic [DIM_BITS-1:0]  rows;
  } win_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } res_t;

endpackage

// File: rtl/lrf_req_if.sv
// lrf_req_if: request channel (valid, ready, fill request / advance payload)
// depends on lrf_pkg for field widths
`timescale 1ns / 1ps

interface lrf_req_if;
  import lrf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [FIELD_BITS-1:0] rect_x;
  logic [FIELD_BITS-1:0] rect_y;
  logic [FIELD_BITS-1:0] rect_w;
  logic [FIELD_BITS-1:0] rect_h;
  logic [FIELD_BITS-1:0] fill_color;

  modport source (output valid, kind, rect_x, rect_y, rect_w, rect_h, fill_color,
                  input ready);
  modport sink (input valid, kind, rect_x, rect_y, rect_w, rect_h, fill_color,
                output ready);
endinterface

// File: rtl/lrf_res_if.sv
// lrf_res_if: result channel (valid, ready, status and display byte)
// no dependencies
`timescale 1ns / 1ps

interface lrf_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, status, out_byte, is_data, last, input ready);
  modport sink (input valid, status, out_byte, is_data, last, output ready);
endinterface

// File: rtl/lcd_rect_fill_byte_sequencer_unit.sv
// lcd_rect_fill_byte_sequencer_unit: top level of the rectangle fill byte sequencer
// depends on lrf_pkg, lrf_req_if, lrf_res_if, lrf_clip and lrf_seq
//
// usage:
//   req carries fill requests (kind 0: rectangle and rgb565 color) and advance
//   slots (kind 1); every request transfer yields exactly one result transfer on
//   res, in order. a fill is clipped to the logical screen and answered accepted,
//   empty or refused (while a fill is in progress); each advance then returns one
//   byte: column set, column window, row set, row window, memory write, then the
//   pixels high byte first, with last on the final byte.
//   cfg_we/cfg_index/cfg_data write panel width, panel height, column offset, row
//   offset and rotation (indexes 0 to 4, others ignored); write them while idle.
// timing:
//   a request passes one input register, then clip, window address add and byte
//   select ahead of the result register.
//   throughput is one transfer per cycle while res.ready is high; the state
//   update of each item lands in the same cycle as its result register load.
// reset (rst, synchronous): no transaction in progress, panel 240x240, offsets 0,
//   rotation 0, both channel stages empty.
// stall: when res.ready is low the result register holds, the input register
//   fills and req.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module lcd_rect_fill_byte_sequencer_unit (
  input  logic                               clk,
  input  logic                               rst,
  lrf_req_if.sink                            req,
  lrf_res_if.source                          res,
  input  logic                               cfg_we,
  input  logic [lrf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [lrf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import lrf_pkg::*;

  cfg_t cfg;
  req_t item;
  logic item_valid;
  win_t win;
  logic take;
  logic res_valid;
  res_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.panel_width   <= PANEL_DIM_RESET;
      cfg.panel_height  <= PANEL_DIM_RESET;
      cfg.column_offset <= '0;
      cfg.row_offset    <= '0;
      cfg.rotation      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PANEL_WIDTH:  cfg.panel_width   <= cfg_data[DIM_BITS-1:0];
        CFG_PANEL_HEIGHT: cfg.panel_height  <= cfg_data[DIM_BITS-1:0];
        CFG_COLUMN_OFF:   cfg.column_offset <= cfg_data[OFF_BITS-1:0];
        CFG_ROW_OFF:      cfg.row_offset    <= cfg_data[OFF_BITS-1:0];
        CFG_ROTATION:     cfg.rotation      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // input stage
  assign req.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.kind       <= req.kind;
      item.rect_x     <= req.rect_x;
      item.rect_y     <= req.rect_y;
      item.rect_w     <= req.rect_w;
      item.rect_h     <= req.rect_h;
      item.fill_color <= req.fill_color;
    end
  end

  lrf_clip u_clip (
    .cfg  (cfg),
    .item (item),
    .win  (win)
  );

  lrf_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .win        (win),
    .out_ready  (res.ready),
    .take       (take),
    .res_valid  (res_valid),
    .result     (result)
  );

  assign res.valid    = res_valid;
  assign res.status   = result.status;
  assign res.out_byte = result.out_byte;
  assign res.is_data  = result.is_data;
  assign res.last     = result.last;

endmodule

// File: rtl/lrf_clip.sv
// lrf_clip: clips a request rectangle to the logical screen and forms the
// column and row window addresses; depends on lrf_pkg
`timescale 1ns / 1ps

module lrf_clip (
  input  lrf_pkg::cfg_t cfg,
  input  lrf_pkg::req_t item,
  output lrf_pkg::win_t win
);
  import lrf_pkg::*;

  typedef struct packed {
    logic                ok;
    logic [DIM_BITS-1:0] start;
    logic [DIM_BITS-1:0] stop;
    logic [DIM_BITS-1:0] count;
  } span_t;

  function automatic span_t clip_span(logic [FIELD_BITS-1:0] p,
                                      logic [FIELD_BITS-1:0] len,
                                      logic [DIM_BITS-1:0] lim);
    logic signed [FIELD_BITS:0] e;
    logic signed [FIELD_BITS:0] lim_s;
    logic signed [FIELD_BITS:0] e_min;
    logic signed [FIELD_BITS:0] a;
    logic signed [FIELD_BITS:0] stop_full;
    logic signed [FIELD_BITS:0] count_full;
    span_t s;
    e          = $signed({p[FIELD_BITS-1], p}) + $signed({len[FIELD_BITS-1], len});
    lim_s      = $signed((FIELD_BITS+1)'(lim));
    e_min      = (e > lim_s) ? lim_s : e;
    a          = p[FIELD_BITS-1] ? '0 : $signed({1'b0, p});
    stop_full  = e_min - $signed((FIELD_BITS+1)'(1));
    count_full = e_min - a;
    s.ok       = !len[FIELD_BITS-1] && (len != '0) && (e_min > a);
    s.start    = a[DIM_BITS-1:0];
    s.stop     = stop_full[DIM_BITS-1:0];
    s.count    = count_full[DIM_BITS-1:0];
    return s;
  endfunction

  function automatic logic [ADDR_BITS-1:0] add_offset(logic [DIM_BITS-1:0] pos,
                                                      logic [OFF_BITS-1:0] off);
    return ADDR_BITS'(pos) + {{(ADDR_BITS-OFF_BITS){off[OFF_BITS-1]}}, off};
  endfunction

  logic [DIM_BITS-1:0] lw;
  logic [DIM_BITS-1:0] lh;
  span_t               cs;
  span_t               rs;

  assign lw = cfg.rotation[0] ? cfg.panel_height : cfg.panel_width;
  assign lh = cfg.rotation[0] ? cfg.panel_width : cfg.panel_height;
  assign cs = clip_span(item.rect_x, item.rect_w, lw);
  assign rs = clip_span(item.rect_y, item.rect_h, lh);

  assign win.ok        = cs.ok && rs.ok;
  assign win.col_start = add_offset(cs.start, cfg.column_offset);
  assign win.col_end   = add_offset(cs.stop, cfg.column_offset);
  assign win.row_start = add_offset(rs.start, cfg.row_offset);
  assign win.row_end   = add_offset(rs.stop, cfg.row_offset);
  assign win.cols      = cs.count;
  assign win.rows      = rs.count;

endmodule

// File: rtl/lrf_seq.sv
// lrf_seq: transaction state, header and pixel byte sequencing, result register
// depends on lrf_pkg; fed by lrf_clip through the top level
`timescale 1ns / 1ps

module lrf_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  input  lrf_pkg::req_t item,
  input  lrf_pkg::win_t win,
  input  logic          out_ready,
  output logic          take,
  output logic          res_valid,
  output lrf_pkg::res_t result
);
  import lrf_pkg::*;

  logic                  busy, busy_next;
  logic [PHASE_BITS-1:0] phase, phase_next;
  logic [ADDR_BITS-1:0]  col_start, col_end, row_start, row_end;
  logic [FIELD_BITS-1:0] color;
  logic [DIM_BITS-1:0]   col_count;
  logic [DIM_BITS-1:0]   cols_left, cols_left_next;
  logic [DIM_BITS-1:0]   rows_left, rows_left_next;
  logic                  low_half, low_half_next;
  logic                  latch_win;
  logic                  fin;
  res_t                  res_next;

  assign take = item_valid && (!res_valid || out_ready);
  assign fin  = (cols_left <= DIM_BITS'(1)) && (rows_left <= DIM_BITS'(1));

  always_comb begin
    busy_next      = busy;
    phase_next     = phase;
    cols_left_next = cols_left;
    rows_left_next = rows_left;
    low_half_next  = low_half;
    latch_win      = 1'b0;
    res_next       = '0;
    if (item.kind == KIND_FILL) begin
      if (busy) begin
        res_next.status = ST_REFUSED;
      end else if (!win.ok) begin
        res_next.status = ST_EMPTY;
      end else begin
        res_next.status = ST_ACCEPTED;
        latch_win       = 1'b1;
        busy_next       = 1'b1;
        phase_next      = PH_COLSET;
        cols_left_next  = win.cols;
        rows_left_next  = win.rows;
        low_half_next   = 1'b0;
      end
    end else if (!busy) begin
      res_next.status = ST_IDLE;
    end else if (phase < PH_PIXELS) begin
      res_next.status  = ST_BYTE;
      res_next.is_data = 1'b1;
      phase_next       = phase + PHASE_BITS'(1);
      case (phase)
        PH_COLSET: begin
          res_next.out_byte = CMD_COLSET;
          res_next.is_data  = 1'b0;
        end
        PH_COL_S_HI: res_next.out_byte = col_start[15:8];
        PH_COL_S_LO: res_next.out_byte = col_start[7:0];
        PH_COL_E_HI: res_next.out_byte = col_end[15:8];
        PH_COL_E_LO: res_next.out_byte = col_end[7:0];
        PH_ROWSET: begin
          res_next.out_byte = CMD_ROWSET;
          res_next.is_data  = 1'b0;
        end
        PH_ROW_S_HI: res_next.out_byte = row_start[15:8];
        PH_ROW_S_LO: res_next.out_byte = row_start[7:0];
        PH_ROW_E_HI: res_next.out_byte = row_end[15:8];
        PH_ROW_E_LO: res_next.out_byte = row_end[7:0];
        default: begin
          res_next.out_byte = CMD_MEMWR;
          res_next.is_data  = 1'b0;
        end
      endcase
    end else if (!low_half) begin
      res_next.status   = ST_BYTE;
      res_next.out_byte = color[15:8];
      res_next.is_data  = 1'b1;
      low_half_next     = 1'b1;
    end else begin
      res_next.status   = ST_BYTE;
      res_next.out_byte = color[7:0];
      res_next.is_data  = 1'b1;
      res_next.last     = fin;
      low_half_next     = 1'b0;
      if (fin) begin
        busy_next      = 1'b0;
        phase_next     = PH_COLSET;
        cols_left_next = '0;
        rows_left_next = '0;
      end else if (cols_left <= DIM_BITS'(1)) begin
        rows_left_next = rows_left - DIM_BITS'(1);
        cols_left_next = col_count;
      end else begin
        cols_left_next = cols_left - DIM_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= PH_COLSET;
      cols_left <= '0;
      rows_left <= '0;
      low_half  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        busy      <= busy_next;
        phase     <= phase_next;
        cols_left <= cols_left_next;
        rows_left <= rows_left_next;
        low_half  <= low_half_next;
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res_next;
    end
    if (take && latch_win) begin
      col_start <= win.col_start;
      col_end   <= win.col_end;
      row_start <= win.row_start;
      row_end   <= win.row_end;
      col_count <= win.cols;
      color     <= item.fill_color;
    end
  end

  a_fill_sets_busy: assert property (@(posedge clk) disable iff (rst)
    take && (item.kind == KIND_FILL) && !busy && win.ok |=> busy)
    else $error("accepted fill did not start a transaction");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    take && res_next.last |=> !busy)
    else $error("transaction still busy after last byte");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> phase <= PH_PIXELS)
    else $error("header phase out of range");

  a_low_half_in_pixels: assert property (@(posedge clk) disable iff (rst)
    low_half |-> busy && (phase == PH_PIXELS))
    else $error("pixel half set outside pixel phase");

  a_counts_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cols_left != '0) && (rows_left != '0))
    else $error("pixel counters empty during transaction");

endmodule
